### design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SPT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("spt assertion failed");

// same-cycle implication checked outside reset
`define SPT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("spt implication failed");

// next-cycle implication checked outside reset
`define SPT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("spt next-cycle implication failed");

`endif

### design/spt_pkg.sv
// shared types, constants and helpers of the speaker to pcm converter
package spt_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS;
  localparam int FILT_BITS   = SAMPLE_BITS + 2;
  localparam int CNT_BITS    = 32;
  localparam int COEF_BITS   = 16;
  localparam int Q_SHIFT     = 15;
  localparam int SUM_BITS    = FILT_BITS + 4;

  localparam logic [COEF_BITS-1:0] Q15_ONE = COEF_BITS'(32768);

  localparam logic [1:0] REG_LOWPASS = 2'd0;
  localparam logic [1:0] REG_DC      = 2'd1;
  localparam logic [1:0] REG_MUTED   = 2'd2;

  typedef enum logic {
    CMD_TOGGLE = 1'b0,
    CMD_SAMPLE = 1'b1
  } spt_cmd_e;

  // filter step strobes, at most one per cycle
  typedef struct packed {
    logic lp_mul;
    logic lp_add;
    logic dc_mul;
    logic dc_add;
    logic speaker;
  } spt_filt_ctrl_t;

  localparam logic signed [SUM_BITS-1:0] FILT_HI = SUM_BITS'((1 << (FILT_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] FILT_LO = -SUM_BITS'(1 << (FILT_BITS - 1));

  function automatic logic signed [FILT_BITS-1:0] sat_filt(
    input logic signed [SUM_BITS-1:0] x
  );
    logic signed [SUM_BITS-1:0] y;
    y = x;
    if (x > FILT_HI) y = FILT_HI;
    if (x < FILT_LO) y = FILT_LO;
    return y[FILT_BITS-1:0];
  endfunction

endpackage

### design/spt_divider.sv
// bit-serial restoring divider forming the signed duty ratio in q2.16
module spt_divider import spt_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [CNT_BITS-1:0]         high_i,
  input  logic [CNT_BITS-1:0]         low_i,
  output logic                        done_o,
  output logic signed [FILT_BITS-1:0] raw_o
);

  localparam int QBITS = FRAC_BITS + 1;
  localparam int DBITS = CNT_BITS + 1;
  localparam int CW    = $clog2(QBITS + 1);
  localparam logic [CW-1:0] SIGN_STEP = CW'(QBITS);

  logic                 busy_q, busy_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [DBITS-1:0]     rem_q, rem_d;
  logic [DBITS-1:0]     total_q, total_d;
  logic [QBITS-1:0]     quo_q, quo_d;
  logic                 neg_q, neg_d;
  logic                 zero_q, zero_d;
  logic signed [FILT_BITS-1:0] raw_q, raw_d;

  logic [DBITS-1:0]     diff;
  logic [CNT_BITS-1:0]  mag;
  logic [DBITS:0]       trial;
  logic [DBITS:0]       trial_sub;
  logic                 ge;
  logic [FILT_BITS-1:0] quo_ext;

  assign diff      = {1'b0, high_i} - {1'b0, low_i};
  assign mag       = diff[CNT_BITS] ? (low_i - high_i) : diff[CNT_BITS-1:0];
  assign trial     = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign trial_sub = trial - {1'b0, total_q};
  assign ge        = trial >= {1'b0, total_q};
  assign quo_ext   = FILT_BITS'(quo_q);

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    total_d = total_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    raw_d   = raw_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      rem_d   = {1'b0, mag};
      total_d = {1'b0, high_i} + {1'b0, low_i};
      neg_d   = diff[CNT_BITS];
      zero_d  = (high_i == '0) && (low_i == '0);
      quo_d   = '0;
    end else if (busy_q) begin
      if (cnt_q == SIGN_STEP) begin
        busy_d = 1'b0;
        if (zero_q) begin
          raw_d = '0;
        end else if (neg_q) begin
          raw_d = -$signed(quo_ext);
        end else begin
          raw_d = $signed(quo_ext);
        end
      end else begin
        rem_d = ge ? trial_sub[DBITS-1:0] : trial[DBITS-1:0];
        quo_d = {quo_q[QBITS-2:0], ge};
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    total_q <= total_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    zero_q  <= zero_d;
    raw_q   <= raw_d;
  end

  assign done_o = busy_q && (cnt_q == SIGN_STEP);
  assign raw_o  = raw_q;

`include "assert_macros.svh"

  `SPT_ASSERT_IMP(a_start_idle, clk_i, rst_ni, start_i, !busy_q)
  `SPT_ASSERT_IMP(a_rem_below, clk_i, rst_ni, busy_q && (cnt_q != '0) && !zero_q, rem_q < total_q)

endmodule

### design/spt_filter.sv
// low-pass, dc tracker and q1.15 conversion on one shared multiplier
module spt_filter import spt_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spt_filt_ctrl_t                ctrl_i,
  input  logic signed [FILT_BITS-1:0]   raw_i,
  input  logic [COEF_BITS-1:0]          lp_coef_i,
  input  logic [COEF_BITS-1:0]          dc_coef_i,
  output logic signed [SAMPLE_BITS-1:0] speaker_o
);

  localparam int PROD_BITS = FILT_BITS + COEF_BITS + 2;
  localparam logic signed [PROD_BITS-1:0] HALF = PROD_BITS'(1 << (Q_SHIFT - 1));
  localparam logic signed [FILT_BITS:0] CORR_HI = (FILT_BITS + 1)'(1 << FRAC_BITS);
  localparam logic signed [FILT_BITS:0] CORR_LO = -(FILT_BITS + 1)'(1 << FRAC_BITS);
  localparam logic signed [FILT_BITS-1:0] SPK_HI = FILT_BITS'((1 << (SAMPLE_BITS - 1)) - 1);

  logic signed [FILT_BITS-1:0]   lp_q, dc_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic signed [SAMPLE_BITS-1:0] spk_q;

  logic signed [FILT_BITS:0]     err;
  logic signed [COEF_BITS:0]     coef;
  logic signed [PROD_BITS-1:0]   prod_rnd;
  logic signed [PROD_BITS-1:0]   prod_shr;
  logic signed [SUM_BITS-1:0]    base;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [FILT_BITS:0]     corr, corr_cl, corr_rnd;
  logic signed [FILT_BITS-1:0]   half;

  always_comb begin
    if (ctrl_i.lp_mul) begin
      err  = (FILT_BITS + 1)'(raw_i) - (FILT_BITS + 1)'(lp_q);
      coef = {1'b0, lp_coef_i};
    end else begin
      err  = (FILT_BITS + 1)'(lp_q) - (FILT_BITS + 1)'(dc_q);
      coef = {1'b0, Q15_ONE - dc_coef_i};
    end
  end

  assign prod_rnd = prod_q + HALF;
  assign prod_shr = prod_rnd >>> Q_SHIFT;
  assign base     = ctrl_i.lp_add ? SUM_BITS'(lp_q) : SUM_BITS'(dc_q);
  assign sum      = base + prod_shr[SUM_BITS-1:0];

  always_comb begin
    corr    = (FILT_BITS + 1)'(lp_q) - (FILT_BITS + 1)'(dc_q);
    corr_cl = corr;
    if (corr > CORR_HI) corr_cl = CORR_HI;
    if (corr < CORR_LO) corr_cl = CORR_LO;
    corr_rnd = (corr_cl + (FILT_BITS + 1)'(1)) >>> 1;
    half     = corr_rnd[FILT_BITS-1:0];
    if (half > SPK_HI) half = SPK_HI;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
      dc_q <= '0;
    end else begin
      if (ctrl_i.lp_add) lp_q <= sat_filt(sum);
      if (ctrl_i.dc_add) dc_q <= sat_filt(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lp_mul || ctrl_i.dc_mul) prod_q <= PROD_BITS'(err) * PROD_BITS'(coef);
    if (ctrl_i.speaker) spk_q <= half[SAMPLE_BITS-1:0];
  end

  assign speaker_o = spk_q;

`include "assert_macros.svh"

  `SPT_ASSERT(a_one_step, clk_i, rst_ni, $onehot0(ctrl_i))

endmodule

### design/speaker_toggle_to_pcm.sv
// Speaker toggle to PCM converter. Toggle and sample-end words arrive in time order on the
// slave stream; toggles accumulate high and low cycle counts, each sample end produces one
// word of left, right and speaker sample on the master stream. A toggle word passes the
// diff and count states; a sample-end word then also passes the bit-serial divider (one
// quotient bit per cycle plus a sign step) and the lp multiply, lp add, dc multiply, dc
// add and speaker steps of the shared filter, then waits while the master side stalls the
// result. The next word is taken while an earlier result still waits on the master side.
module speaker_toggle_to_pcm import spt_pkg::*; #(
  parameter int STAMP_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // cycle_stamp, extra_left, extra_right, zero pad
  input  logic [((STAMP_BITS+2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // left_out, right_out, speaker_level_out
  output logic [3*SAMPLE_BITS-1:0]               m_axis_tdata,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_index_i,
  input  logic [COEF_BITS-1:0]                   cfg_data_i
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_DIFF      = 11'b000_0000_0010,
    ST_COUNT     = 11'b000_0000_0100,
    ST_DIV_START = 11'b000_0000_1000,
    ST_DIVIDE    = 11'b000_0001_0000,
    ST_LP_MUL    = 11'b000_0010_0000,
    ST_LP_ADD    = 11'b000_0100_0000,
    ST_DC_MUL    = 11'b000_1000_0000,
    ST_DC_ADD    = 11'b001_0000_0000,
    ST_SPEAKER   = 11'b010_0000_0000,
    ST_EMIT      = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [COEF_BITS-1:0]   lp_coef_q, dc_coef_q;
  logic                   muted_q;
  logic                   level_q;
  logic [STAMP_BITS-1:0]  last_q;
  logic [CNT_BITS-1:0]    high_q, low_q;

  spt_cmd_e                     cmd_q;
  logic [STAMP_BITS-1:0]        stamp_q, diff_q;
  logic signed [SAMPLE_BITS-1:0] el_q, er_q;

  logic                     m_valid_q;
  logic [3*SAMPLE_BITS-1:0] m_data_q;

  logic                     in_fire, emit_fire, older;
  logic [CNT_BITS-1:0]      elapsed, ctr_cur, ctr_new;
  logic                     elapsed_over;
  logic [CNT_BITS:0]        ctr_sum;
  logic [COEF_BITS-1:0]     lp_eff, dc_eff;
  logic                     div_done;
  logic signed [FILT_BITS-1:0]   raw;
  logic signed [SAMPLE_BITS-1:0] spk;
  logic signed [SAMPLE_BITS+1:0] sum_l, sum_r;
  logic [SAMPLE_BITS-1:0]        left, right;
  spt_filt_ctrl_t                fctl;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign emit_fire     = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  generate
    if (STAMP_BITS > CNT_BITS) begin : g_wide
      assign elapsed      = diff_q[CNT_BITS-1:0];
      assign elapsed_over = |diff_q[STAMP_BITS-1:CNT_BITS];
    end else begin : g_narrow
      assign elapsed      = CNT_BITS'(diff_q);
      assign elapsed_over = 1'b0;
    end
  endgenerate

  assign older   = diff_q[STAMP_BITS-1];
  assign ctr_cur = level_q ? high_q : low_q;
  assign ctr_sum = {1'b0, ctr_cur} + {1'b0, elapsed};
  assign ctr_new = (elapsed_over || ctr_sum[CNT_BITS]) ? '1 : ctr_sum[CNT_BITS-1:0];

  assign lp_eff = (lp_coef_q > Q15_ONE) ? Q15_ONE : lp_coef_q;
  assign dc_eff = (dc_coef_q > Q15_ONE) ? Q15_ONE : dc_coef_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_fire) state_d = ST_DIFF;
      ST_DIFF:      state_d = ST_COUNT;
      ST_COUNT:     state_d = (cmd_q == CMD_SAMPLE) ? ST_DIV_START : ST_IDLE;
      ST_DIV_START: state_d = ST_DIVIDE;
      ST_DIVIDE:    if (div_done) state_d = ST_LP_MUL;
      ST_LP_MUL:    state_d = ST_LP_ADD;
      ST_LP_ADD:    state_d = ST_DC_MUL;
      ST_DC_MUL:    state_d = ST_DC_ADD;
      ST_DC_ADD:    state_d = ST_SPEAKER;
      ST_SPEAKER:   state_d = ST_EMIT;
      ST_EMIT:      if (emit_fire) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lp_coef_q <= COEF_BITS'(16384);
      dc_coef_q <= COEF_BITS'(32604);
      muted_q   <= 1'b0;
      level_q   <= 1'b0;
      last_q    <= '0;
      high_q    <= '0;
      low_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LOWPASS: lp_coef_q <= cfg_data_i;
          REG_DC:      dc_coef_q <= cfg_data_i;
          REG_MUTED:   muted_q   <= cfg_data_i[0];
          default:     ;
        endcase
      end
      if (state_q == ST_COUNT) begin
        if (!older) begin
          if (level_q) high_q <= ctr_new;
          else         low_q  <= ctr_new;
        end
        if (cmd_q == CMD_TOGGLE) begin
          level_q <= ~level_q;
          if (!older) last_q <= stamp_q;
        end else begin
          last_q <= stamp_q;
        end
      end
      if (state_q == ST_DIV_START) begin
        high_q <= '0;
        low_q  <= '0;
      end
      if (emit_fire)          m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= spt_cmd_e'(s_axis_tuser);
      stamp_q <= s_axis_tdata[STAMP_BITS-1:0];
      el_q    <= s_axis_tdata[STAMP_BITS +: SAMPLE_BITS];
      er_q    <= s_axis_tdata[STAMP_BITS+SAMPLE_BITS +: SAMPLE_BITS];
    end
    if (state_q == ST_DIFF) diff_q <= stamp_q - last_q;
    if (emit_fire) m_data_q <= {spk, right, left};
  end

  spt_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DIV_START),
    .high_i  (high_q),
    .low_i   (low_q),
    .done_o  (div_done),
    .raw_o   (raw)
  );

  assign fctl.lp_mul  = (state_q == ST_LP_MUL);
  assign fctl.lp_add  = (state_q == ST_LP_ADD);
  assign fctl.dc_mul  = (state_q == ST_DC_MUL);
  assign fctl.dc_add  = (state_q == ST_DC_ADD);
  assign fctl.speaker = (state_q == ST_SPEAKER);

  spt_filter u_filt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (fctl),
    .raw_i     (raw),
    .lp_coef_i (lp_eff),
    .dc_coef_i (dc_eff),
    .speaker_o (spk)
  );

  // halved mix, always within range
  assign sum_l = (SAMPLE_BITS + 2)'(spk) + (SAMPLE_BITS + 2)'(el_q) + (SAMPLE_BITS + 2)'(1);
  assign sum_r = (SAMPLE_BITS + 2)'(spk) + (SAMPLE_BITS + 2)'(er_q) + (SAMPLE_BITS + 2)'(1);
  assign left  = muted_q ? '0 : sum_l[SAMPLE_BITS:1];
  assign right = muted_q ? '0 : sum_r[SAMPLE_BITS:1];

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`include "assert_macros.svh"

  `SPT_ASSERT_IMP(a_done_in_divide, clk_i, rst_ni, div_done, state_q == ST_DIVIDE)
  `SPT_ASSERT_NEXT(a_window_cleared, clk_i, rst_ni, state_q == ST_DIV_START, (high_q == '0) && (low_q == '0))

endmodule
